// ----- rtl/core/great_circle_distance_unit_assert.svh -----
// Assertion macros shared by the great-circle distance unit.
`ifndef GREAT_CIRCLE_DISTANCE_UNIT_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// Next-cycle implication, checked outside reset.
`define GCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ----- rtl/core/gcd_pkg.sv -----
// Shared types, constants and the arctangent table of the great-circle distance unit.
package gcd_pkg;

  localparam int unsigned LonW  = 31;
  localparam int unsigned LatW  = 30;
  localparam int unsigned DistW = 23;
  localparam int unsigned AngW  = 33;
  localparam int unsigned RedW  = AngW + 2;
  localparam int unsigned MagW  = 30;
  localparam int unsigned DataW = 34;
  localparam int unsigned FracW = 30;
  localparam int unsigned SqrtW = 31;
  localparam int unsigned RemW  = 61;

  localparam logic signed [RedW-1:0] FullTurn    = 35'sd3019898880;
  localparam logic signed [RedW-1:0] HalfTurn    = 35'sd1509949440;
  localparam logic signed [RedW-1:0] QuarterTurn = 35'sd754974720;

  localparam logic [31:0] PiQ30    = 32'd3373259426;
  localparam logic [61:0] RadBias  = 62'd754974720;
  localparam logic [31:0] Recip45  = 32'd3054198965;
  localparam logic [63:0] Q30Half  = 64'd536870912;
  localparam logic [30:0] Q30One   = 31'd1073741824;
  localparam logic [20:0] Km256    = 21'd1630976;
  localparam logic [DistW-1:0] DistMax = 23'd5124000;

  localparam logic signed [DataW-1:0] GainQ30 = 34'sd652032874;

  typedef enum logic {
    ModeRotate,
    ModeVector
  } cordic_mode_e;

  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic signed [DataW-1:0] y;
    logic signed [DataW-1:0] z;
    logic                    tag;
  } cordic_t;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [SqrtW-1:0] root;
  } sqrt_t;

  function automatic logic signed [DataW-1:0] atan_q30(logic [4:0] idx);
    logic signed [DataW-1:0] v;
    case (idx)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd10: v = 34'sd1048576;
      5'd11: v = 34'sd524288;
      5'd12: v = 34'sd262144;
      5'd13: v = 34'sd131072;
      5'd14: v = 34'sd65536;
      5'd15: v = 34'sd32768;
      5'd16: v = 34'sd16384;
      5'd17: v = 34'sd8192;
      5'd18: v = 34'sd4096;
      5'd19: v = 34'sd2048;
      5'd20: v = 34'sd1024;
      5'd21: v = 34'sd512;
      5'd22: v = 34'sd256;
      5'd23: v = 34'sd128;
      5'd24: v = 34'sd64;
      5'd25: v = 34'sd32;
      5'd26: v = 34'sd16;
      5'd27: v = 34'sd8;
      5'd28: v = 34'sd4;
      5'd29: v = 34'sd2;
      5'd30: v = 34'sd1;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/gcd_req_if.sv -----
// Request channel: two positions in, valid/ready handshake.
interface gcd_req_if import gcd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [LonW-1:0] first_lon;
  logic signed [LatW-1:0] first_lat;
  logic signed [LonW-1:0] second_lon;
  logic signed [LatW-1:0] second_lat;

  modport source (output valid, first_lon, first_lat, second_lon, second_lat, input ready);
  modport sink (input valid, first_lon, first_lat, second_lon, second_lat, output ready);
endinterface

// ----- rtl/core/gcd_rsp_if.sv -----
// Result channel: one distance out, valid/ready handshake.
interface gcd_rsp_if import gcd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DistW-1:0] distance_km;

  modport source (output valid, distance_km, input ready);
  modport sink (input valid, distance_km, output ready);
endinterface

// ----- rtl/core/gcd_angle_prep.sv -----
// Angle front end: wrap to a half turn, fold to a quarter turn, convert to Q30 radians.
module gcd_angle_prep import gcd_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [AngW-1:0] angle_i,
  output logic                   valid_o,
  output cordic_t                data_o
);

  logic [3:0] valid_q;

  logic signed [RedW-1:0] ext, red_d, red_q, fold;
  logic [MagW-1:0]        mag_d, mag_q;
  logic                   flip_d, flip2_q, flip3_q, flip4_q;
  logic                   neg_d, neg2_q, neg3_q, neg4_q;
  logic [61:0]            num_d, num_q;
  logic [63:0]            quo_prod;
  logic [36:0]            mdiv_q;
  logic [31:0]            qest_q;
  logic [37:0]            rem;
  logic [31:0]            quo;
  logic signed [DataW-1:0] z_d;

  // wrap into [-half, half)
  always_comb begin
    ext = RedW'(angle_i);
    if (ext >= HalfTurn) begin
      red_d = ext - FullTurn;
    end else if (ext < -HalfTurn) begin
      red_d = ext + FullTurn;
    end else begin
      red_d = ext;
    end
  end

  // fold about +-90 degrees, cosine flips sign
  always_comb begin
    flip_d = 1'b0;
    if (red_q > QuarterTurn) begin
      fold   = HalfTurn - red_q;
      flip_d = 1'b1;
    end else if (red_q < -QuarterTurn) begin
      fold   = -HalfTurn - red_q;
      flip_d = 1'b1;
    end else begin
      fold = red_q;
    end
    neg_d = fold[RedW-1];
    mag_d = neg_d ? MagW'(-fold) : MagW'(fold);
  end

  assign num_d    = 62'(mag_q) * 62'(PiQ30) + RadBias;
  assign quo_prod = 64'(num_q[61:30]) * 64'(Recip45);

  // estimate is low by at most two: correct against the remainder
  always_comb begin
    rem = 38'(mdiv_q) - 38'(qest_q) * 38'd45;
    quo = qest_q + 32'(rem >= 38'd45) + 32'(rem >= 38'd90);
    z_d = neg4_q ? -DataW'(quo) : DataW'(quo);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
      valid_o <= valid_q[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      red_q   <= red_d;
      mag_q   <= mag_d;
      flip2_q <= flip_d;
      neg2_q  <= neg_d;
      num_q   <= num_d;
      flip3_q <= flip2_q;
      neg3_q  <= neg2_q;
      mdiv_q  <= num_q[61:25];
      qest_q  <= quo_prod[63:32];
      flip4_q <= flip3_q;
      neg4_q  <= neg3_q;
      data_o  <= '{x: GainQ30, y: '0, z: z_d, tag: flip4_q};
    end
  end

endmodule

// ----- rtl/core/gcd_cordic_cell.sv -----
// One CORDIC micro-rotation, registered; rotation or vectoring by parameter.
module gcd_cordic_cell import gcd_pkg::*; #(
  parameter int unsigned  Stage = 0,
  parameter cordic_mode_e Mode  = ModeRotate
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    en_i,
  input  logic    valid_i,
  input  cordic_t data_i,
  output logic    valid_o,
  output cordic_t data_o
);

  localparam logic signed [DataW-1:0] Angle = atan_q30(5'(Stage));

  logic signed [DataW-1:0] dx, dy;
  logic                    cw;
  cordic_t                 data_d;

  always_comb begin
    dx = data_i.y >>> Stage;
    dy = data_i.x >>> Stage;
    cw = (Mode == ModeRotate) ? data_i.z[DataW-1] : ~data_i.y[DataW-1];
    data_d.tag = data_i.tag;
    if (cw) begin
      data_d.x = data_i.x + dx;
      data_d.y = data_i.y - dy;
      data_d.z = data_i.z + Angle;
    end else begin
      data_d.x = data_i.x - dx;
      data_d.y = data_i.y + dy;
      data_d.z = data_i.z - Angle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= data_d;
    end
  end

endmodule

// ----- rtl/core/gcd_sqrt_cell.sv -----
// One result bit of a restoring integer square root, registered.
module gcd_sqrt_cell import gcd_pkg::*; #(
  parameter int unsigned Bit = 0
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  sqrt_t data_i,
  output logic  valid_o,
  output sqrt_t data_o
);

  logic [RemW-1:0] trial;
  logic            fits;
  sqrt_t           data_d;

  // (root + 2^k)^2 - root^2 = root*2^(k+1) + 2^(2k)
  always_comb begin
    trial = (RemW'(data_i.root) << (Bit + 1)) | (RemW'(1) << (2 * Bit));
    fits  = data_i.rem >= trial;
    data_d.rem  = fits ? data_i.rem - trial : data_i.rem;
    data_d.root = data_i.root | (SqrtW'(fits) << Bit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_o <= data_d;
    end
  end

endmodule

// ----- rtl/core/great_circle_distance_unit.sv -----
// Top level of the pipelined haversine great-circle distance unit.
//
//   channel | dir | handshake         | payload
//   req_i   | in  | valid / ready     | first_lon, first_lat, second_lon, second_lat
//   rsp_o   | out | valid / ready     | distance_km (1/256 km)
//
// Takes one request per cycle while ready is high; every request yields exactly one result.
// Pipeline depth is set mostly by the two CORDIC cell chains and the 31-cell square root chain.
// Reset clears only valid bits; no clearing pass is needed.
// A stalled result sits in the output register and a second one in a skid
// register; only a full skid register stops the whole pipe and drops ready.
`include "great_circle_distance_unit_assert.svh"

module great_circle_distance_unit import gcd_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gcd_req_if.sink   req_i,
  gcd_rsp_if.source rsp_o
);

  localparam int unsigned NumLanes = 4;

  // Lane order: latitude 1, latitude 2, latitude difference, longitude difference.
  localparam int unsigned LaneLat1 = 0;
  localparam int unsigned LaneLat2 = 1;
  localparam int unsigned LanePhi  = 2;
  localparam int unsigned LaneLam  = 3;

  function automatic logic [31:0] mag32(logic signed [DataW-1:0] v);
    return v[DataW-1] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [31:0] round_q30(logic [63:0] p);
    logic [64:0] s;
    s = 65'(p) + 65'(Q30Half);
    return 32'(s >> FracW);
  endfunction

  // whole pipe advances together; only the skid register can stop it
  logic en, take, produce;

  // input stage
  logic                   s0_valid_q;
  logic signed [AngW-1:0] ang_q [NumLanes];

  // sine/cosine lanes
  logic    rot_valid [NumLanes][CORDIC_STAGES+1];
  cordic_t rot_data  [NumLanes][CORDIC_STAGES+1];
  logic    rot_done;

  // haversine products
  logic        p1_valid_q, p2_valid_q, p3_valid_q, p4_valid_q;
  logic [63:0] p1_sp_q, p1_c_q, p1_sl_q;
  logic        p1_neg_q, p2_neg_q, p3_neg_q, cos_neg;
  logic [31:0] p2_sp_q, p2_c_q, p2_sl_q, p3_sp_q, term_mag;
  logic [63:0] p3_prod_q;
  logic signed [34:0] term, hav;
  logic [30:0] a_d, a_q;

  // square roots of a and 1-a
  logic  sq_valid [2][SqrtW+1];
  sqrt_t sq_data  [2][SqrtW+1];

  // atan2 chain
  logic    vec_valid [CORDIC_STAGES+1];
  cordic_t vec_data  [CORDIC_STAGES+1];

  // scale to distance
  logic                   f1_valid_q;
  logic signed [DataW:0]  ang2;
  logic [31:0]            c_mag;
  logic [52:0]            f1_prod_q;
  logic [53:0]            dist_sum;
  logic [23:0]            dist_full;
  logic [DistW-1:0]       res_dist;

  // output and skid registers
  logic             out_valid_q, skid_valid_q;
  logic [DistW-1:0] out_dist_q, skid_dist_q;

  assign en          = ~skid_valid_q;
  assign req_i.ready = en;
  assign take        = out_valid_q & rsp_o.ready;
  assign produce     = en & f1_valid_q;

  // Input: angles in 2^-23 degree, so half differences stay exact.
  always_ff @(posedge clk_i) begin
    if (en) begin
      ang_q[LaneLat1] <= AngW'(req_i.first_lat) <<< 1;
      ang_q[LaneLat2] <= AngW'(req_i.second_lat) <<< 1;
      ang_q[LanePhi]  <= AngW'(req_i.second_lat) - AngW'(req_i.first_lat);
      ang_q[LaneLam]  <= AngW'(req_i.second_lon) - AngW'(req_i.first_lon);
    end
  end

  // Four independent rotation chains, one per angle.
  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    gcd_angle_prep u_prep (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (s0_valid_q),
      .angle_i (ang_q[l]),
      .valid_o (rot_valid[l][0]),
      .data_o  (rot_data[l][0])
    );
    for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_rot
      gcd_cordic_cell #(
        .Stage (s),
        .Mode  (ModeRotate)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (rot_valid[l][s]),
        .data_i  (rot_data[l][s]),
        .valid_o (rot_valid[l][s+1]),
        .data_o  (rot_data[l][s+1])
      );
    end
  end

  assign rot_done = rot_valid[LaneLat1][CORDIC_STAGES] & rot_valid[LaneLat2][CORDIC_STAGES]
                  & rot_valid[LanePhi][CORDIC_STAGES] & rot_valid[LaneLam][CORDIC_STAGES];

  // Cosine sign: x sign, inverted by the fold flag carried in tag.
  assign cos_neg = (rot_data[LaneLat1][CORDIC_STAGES].x[DataW-1]
                    ^ rot_data[LaneLat1][CORDIC_STAGES].tag)
                 ^ (rot_data[LaneLat2][CORDIC_STAGES].x[DataW-1]
                    ^ rot_data[LaneLat2][CORDIC_STAGES].tag);

  // Clamp a into [0, 1] so both square roots see a legal operand.
  always_comb begin
    term_mag = round_q30(p3_prod_q);
    term     = $signed({3'b000, term_mag});
    if (p3_neg_q) begin
      term = -term;
    end
    hav = $signed({3'b000, p3_sp_q}) + term;
    if (hav < 0) begin
      a_d = '0;
    end else if (hav > $signed({4'b0000, Q30One})) begin
      a_d = Q30One;
    end else begin
      a_d = 31'(hav);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_sp_q   <= 64'(mag32(rot_data[LanePhi][CORDIC_STAGES].y))
                 * 64'(mag32(rot_data[LanePhi][CORDIC_STAGES].y));
      p1_c_q    <= 64'(mag32(rot_data[LaneLat1][CORDIC_STAGES].x))
                 * 64'(mag32(rot_data[LaneLat2][CORDIC_STAGES].x));
      p1_sl_q   <= 64'(mag32(rot_data[LaneLam][CORDIC_STAGES].y))
                 * 64'(mag32(rot_data[LaneLam][CORDIC_STAGES].y));
      p1_neg_q  <= cos_neg;
      p2_sp_q   <= round_q30(p1_sp_q);
      p2_c_q    <= round_q30(p1_c_q);
      p2_sl_q   <= round_q30(p1_sl_q);
      p2_neg_q  <= p1_neg_q;
      p3_prod_q <= 64'(p2_c_q) * 64'(p2_sl_q);
      p3_sp_q   <= p2_sp_q;
      p3_neg_q  <= p2_neg_q;
      a_q       <= a_d;
    end
  end

  // Operands a*2^30 and (1-a)*2^30 give Q30 roots.
  assign sq_data[0][0]  = '{rem: {a_q, {FracW{1'b0}}}, root: '0};
  assign sq_data[1][0]  = '{rem: {Q30One - a_q, {FracW{1'b0}}}, root: '0};
  assign sq_valid[0][0] = p4_valid_q;
  assign sq_valid[1][0] = p4_valid_q;

  for (genvar c = 0; c < 2; c++) begin : g_sqrt
    for (genvar b = 0; b < SqrtW; b++) begin : g_bit
      gcd_sqrt_cell #(
        .Bit (SqrtW - 1 - b)
      ) u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .en_i    (en),
        .valid_i (sq_valid[c][b]),
        .data_i  (sq_data[c][b]),
        .valid_o (sq_valid[c][b+1]),
        .data_o  (sq_data[c][b+1])
      );
    end
  end

  // atan2(sqrt a, sqrt(1-a)) by vectoring toward the x axis.
  assign vec_data[0]  = '{x: DataW'(sq_data[1][SqrtW].root),
                          y: DataW'(sq_data[0][SqrtW].root),
                          z: '0, tag: 1'b0};
  assign vec_valid[0] = sq_valid[0][SqrtW] & sq_valid[1][SqrtW];

  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_vec
    gcd_cordic_cell #(
      .Stage (s),
      .Mode  (ModeVector)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vec_valid[s]),
      .data_i  (vec_data[s]),
      .valid_o (vec_valid[s+1]),
      .data_o  (vec_data[s+1])
    );
  end

  // c = 2*z, negative residue dropped to zero, then scale by 6371*256.
  always_comb begin
    ang2  = {vec_data[CORDIC_STAGES].z, 1'b0};
    c_mag = ang2[DataW] ? '0 : 32'(ang2);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_prod_q <= 53'(c_mag) * 53'(Km256);
    end
  end

  // Round and saturate the distance.
  always_comb begin
    dist_sum  = 54'(f1_prod_q) + 54'(Q30Half);
    dist_full = 24'(dist_sum >> FracW);
    res_dist  = (dist_full > 24'(DistMax)) ? DistMax : DistW'(dist_full);
  end

  // Valid bits of the top-level stages and the output side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q   <= 1'b0;
      p1_valid_q   <= 1'b0;
      p2_valid_q   <= 1'b0;
      p3_valid_q   <= 1'b0;
      p4_valid_q   <= 1'b0;
      f1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (en) begin
        s0_valid_q <= req_i.valid;
        p1_valid_q <= rot_done;
        p2_valid_q <= p1_valid_q;
        p3_valid_q <= p2_valid_q;
        p4_valid_q <= p3_valid_q;
        f1_valid_q <= vec_valid[CORDIC_STAGES];
      end
      if (skid_valid_q) begin
        // drain the skid register once the output slot frees up
        if (take) begin
          skid_valid_q <= 1'b0;
        end
      end else if (produce) begin
        if (out_valid_q && !rsp_o.ready) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end else if (take) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_dist_q <= skid_dist_q;
      end
    end else if (produce) begin
      if (out_valid_q && !rsp_o.ready) begin
        skid_dist_q <= res_dist;
      end else begin
        out_dist_q <= res_dist;
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.distance_km = out_dist_q;

  `GCD_ASSERT_IMP(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  `GCD_ASSERT_IMP(a_dist_in_range, clk_i, rst_ni, out_valid_q, out_dist_q <= DistMax)
  `GCD_ASSERT_IMP(a_hav_clamped, clk_i, rst_ni, p4_valid_q, a_q <= Q30One)
  `GCD_ASSERT_NXT(a_stall_fills_skid, clk_i, rst_ni, out_valid_q && !rsp_o.ready && f1_valid_q && !skid_valid_q, skid_valid_q && out_valid_q)

endmodule

// ----- dv/great_circle_distance_unit_test.sv -----
// Self-checking testbench for the haversine great-circle distance unit.
module great_circle_distance_unit_test;
  import gcd_pkg::*;

  localparam longint Deg       = 4194304;
  localparam longint FullTurnL = 64'sd3019898880;
  localparam longint HalfTurnL = 1509949440;
  localparam longint QuartTurn = 754974720;
  localparam longint PiL       = 64'sd3373259426;
  localparam longint GainL     = 652032874;
  localparam longint OneL      = 1073741824;
  localparam longint HalfL     = 536870912;
  localparam longint KmL       = 1630976;
  localparam longint MaxDist   = 5124000;
  localparam int     Stages    = 24;
  localparam int     NumRandom = 800;

  typedef struct {
    logic signed [LonW-1:0] lon1;
    logic signed [LatW-1:0] lat1;
    logic signed [LonW-1:0] lon2;
    logic signed [LatW-1:0] lat2;
  } position_pair_t;

  typedef struct {
    position_pair_t         pair;
    bit                     known;  // distance typed in below, else predicted
    logic [DistW-1:0]       want_km;
  } route_row_t;

  logic clk_i;
  logic rst_ni;
  int   fail_count;

  gcd_req_if req_if ();
  gcd_rsp_if rsp_if ();

  great_circle_distance_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Distances still owed by the pipe, oldest first.
  logic [DistW-1:0] pending_dist_q[$];
  // Hand-computed distances for the next accepted requests; -1 means predict.
  longint           typed_dist_q[$];

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------
  // Distance predictor, in 2^-23 degree angles and Q30 fractions
  // ---------------------------------------------------------------------
  function automatic longint atan_step(int i);
    longint tbl[32] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
      32, 16, 8, 4, 2, 1, 0};
    return tbl[i & 31];
  endfunction

  // Round the Q30 product half away from zero.
  function automatic longint q30_mul(longint a, longint b);
    bit     neg;
    longint r;
    neg = (a < 0) != (b < 0);
    r = ((a < 0 ? -a : a) * (b < 0 ? -b : b) + HalfL) >>> 30;
    return neg ? -r : r;
  endfunction

  function automatic void rotate_angle(input longint ang, output longint s,
                                       output longint c);
    longint r, ur, z, x, y, dx, dy;
    bit     flip;
    flip = 1'b0;
    r = ang % FullTurnL;
    if (r >= HalfTurnL) r -= FullTurnL;
    if (r < -HalfTurnL) r += FullTurnL;
    // Fold past the quarter turn; cosine changes sign.
    if (r > QuartTurn) begin
      r = HalfTurnL - r;
      flip = 1'b1;
    end else if (r < -QuartTurn) begin
      r = -HalfTurnL - r;
      flip = 1'b1;
    end
    ur = r < 0 ? -r : r;
    z = (ur * PiL + HalfTurnL / 2) / HalfTurnL;
    if (r < 0) z = -z;
    x = GainL;
    y = 0;
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step(i);
      end else begin
        x += dx; y -= dy; z += atan_step(i);
      end
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z, dx, dy;
    z = 0;
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step(i);
      end else begin
        x -= dx; y += dy; z -= atan_step(i);
      end
    end
    return z;
  endfunction

  function automatic longint floor_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic logic [DistW-1:0] haversine_dist(position_pair_t p);
    longint s1, c1, s2, c2, sp, cp, sl, cl, a, ra, rb, c, d;
    rotate_angle(2 * longint'(p.lat1), s1, c1);
    rotate_angle(2 * longint'(p.lat2), s2, c2);
    rotate_angle(longint'(p.lat2) - longint'(p.lat1), sp, cp);
    rotate_angle(longint'(p.lon2) - longint'(p.lon1), sl, cl);
    a = q30_mul(sp, sp) + q30_mul(q30_mul(c1, c2), q30_mul(sl, sl));
    if (a < 0) a = 0;
    if (a > OneL) a = OneL;
    ra = floor_root(longint'(a) << 30);
    rb = floor_root(longint'(OneL - a) << 30);
    c = 2 * vector_angle(ra, rb);
    if (c < 0) c = 0;
    d = (c * KmL + HalfL) >>> 30;
    if (d > MaxDist) d = MaxDist;
    return d[DistW-1:0];
  endfunction

  // ---------------------------------------------------------------------
  // Monitors: predict on every accepted request, check every result
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    position_pair_t   p;
    longint           typed;
    logic [DistW-1:0] want;
    if (rst_ni && req_if.valid && req_if.ready) begin
      p.lon1 = req_if.first_lon;
      p.lat1 = req_if.first_lat;
      p.lon2 = req_if.second_lon;
      p.lat2 = req_if.second_lat;
      typed = typed_dist_q.size() != 0 ? typed_dist_q.pop_front() : -1;
      want = typed >= 0 ? typed[DistW-1:0] : haversine_dist(p);
      pending_dist_q.insert(pending_dist_q.size(), want);
    end
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_dist_q.size() == 0) begin
        $error("distance_km: unexpected result %0d", rsp_if.distance_km);
        fail_count++;
      end else begin
        want = pending_dist_q.pop_front();
        if (rsp_if.distance_km !== want) begin
          $error("distance_km: expected %0d, got %0d", want, rsp_if.distance_km);
          fail_count++;
        end
      end
    end
  end

  // Mostly short gaps, now and then a long one, often none at all.
  function automatic int gap_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: stall the sink at random, with calm stretches in between.
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = gap_len();
      if (stall != 0) begin
        rsp_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
  end

  // Present one request from the falling edge on and hold it until taken.
  task automatic send_request(position_pair_t p);
    int gap;
    gap = gap_len();
    if (gap != 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.first_lon  = p.lon1;
    req_if.first_lat  = p.lat1;
    req_if.second_lon = p.lon2;
    req_if.second_lat = p.lat2;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  function automatic position_pair_t random_pair();
    position_pair_t p;
    int             roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      // Any bit pattern the fields allow, wrapped modulo a full turn.
      p.lon1 = LonW'($urandom);
      p.lat1 = LatW'($urandom);
      p.lon2 = LonW'($urandom);
      p.lat2 = LatW'($urandom);
    end else begin
      p.lon1 = LonW'(longint'($urandom_range(0, 2 * QuartTurn)) - QuartTurn);
      p.lat1 = LatW'(longint'($urandom_range(0, QuartTurn)) - QuartTurn / 2);
      if (roll < 35) begin
        // Nearby points: short routes where rounding dominates.
        p.lon2 = LonW'(longint'(p.lon1) + longint'($urandom_range(0, 2000000)) - 1000000);
        p.lat2 = LatW'(longint'(p.lat1) + longint'($urandom_range(0, 2000000)) - 1000000);
      end else begin
        p.lon2 = LonW'(longint'($urandom_range(0, 2 * QuartTurn)) - QuartTurn);
        p.lat2 = LatW'(longint'($urandom_range(0, QuartTurn)) - QuartTurn / 2);
      end
    end
    return p;
  endfunction

  // ---------------------------------------------------------------------
  // Directed routes: extremes, poles, the date line and wrapped angles
  // ---------------------------------------------------------------------
  route_row_t route_table[] = '{
    '{'{0, 0, 0, 0}, 1'b1, 0},                                     // origin to itself
    '{'{123 * Deg, 45 * Deg, 123 * Deg, 45 * Deg}, 1'b1, 0},       // same point
    '{'{0, 0, 180 * Deg, 0}, 1'b0, 0},                             // antipode on equator
    '{'{0, 90 * Deg, 0, -90 * Deg}, 1'b0, 0},                      // pole to pole
    '{'{-180 * Deg, 90 * Deg, 180 * Deg, 90 * Deg}, 1'b0, 0},      // north pole, lon ends
    '{'{179 * Deg, 10 * Deg, -179 * Deg, 10 * Deg}, 1'b0, 0},      // across the date line
    '{'{0, 0, 1, 0}, 1'b0, 0},                                     // one step apart
    '{'{0, 0, 0, 1}, 1'b0, 0},
    '{'{-180 * Deg, -90 * Deg, 180 * Deg, 90 * Deg}, 1'b0, 0},     // range corners
    '{'{200 * Deg, 100 * Deg, -160 * Deg, 80 * Deg}, 1'b0, 0},     // out of range, wrapped
    '{'{-(1 << 30), -(1 << 29), (1 << 30) - 1, (1 << 29) - 1}, 1'b0, 0}, // field extremes
    '{'{(1 << 30) - 1, (1 << 29) - 1, -(1 << 30), -(1 << 29)}, 1'b0, 0},
    '{'{-(1 << 30), -(1 << 29), -(1 << 30), -(1 << 29)}, 1'b1, 0}, // extreme, same point
    '{'{10 * Deg, 0, -170 * Deg, 0}, 1'b0, 0},                     // near antipode clamp
    '{'{0, 45 * Deg, 180 * Deg, 45 * Deg}, 1'b0, 0},
    '{'{90 * Deg, 0, -90 * Deg, 0}, 1'b0, 0}
  };

  initial begin
    req_if.valid      = 1'b0;
    req_if.first_lon  = '0;
    req_if.first_lat  = '0;
    req_if.second_lon = '0;
    req_if.second_lat = '0;
    fail_count = 0;
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (route_table[i]) begin
      typed_dist_q.insert(typed_dist_q.size(),
                          route_table[i].known ? longint'(route_table[i].want_km) : -1);
      send_request(route_table[i].pair);
    end

    for (int n = 0; n < NumRandom; n++) begin
      // Hold off once until the pipe has drained completely.
      if (n == NumRandom / 2) begin
        req_if.valid = 1'b0;
        wait (pending_dist_q.size() == 0);
        @(negedge clk_i);
      end
      send_request(random_pair());
    end
    req_if.valid = 1'b0;

    wait (pending_dist_q.size() == 0);
    repeat (2 * Stages + 60) @(posedge clk_i);
    if (pending_dist_q.size() != 0) begin
      $error("distance_km: %0d results never arrived", pending_dist_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(12 * 400000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
